FILE: rtl/mad_pkg.sv
// shared types, constants and register indexes for the mirror angle to dac frame block
// no dependencies

package mad_pkg;

   // default values for the top-level parameters
   localparam int ANGLE_FRAC_BITS_DEF = 10;
   localparam int CODE_WIDTH_DEF      = 16;

   // fixed field widths
   localparam int ANGLE_W = 16;
   localparam int LIMIT_W = 15;
   localparam int CODE_W  = 16;
   localparam int GAIN_W  = 24;
   localparam int FRAME_W = 24;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 3;

   // signed angle times gain with a zero sign bit in front
   localparam int PROD_W = ANGLE_W + GAIN_W + 1;

   localparam int NUM_FRAMES = 4;
   localparam int SLOT_W     = 2;

   // op codes
   localparam logic OP_INIT  = 1'b0;
   localparam logic OP_ANGLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_LIMIT_X = 3'd0,
      CSR_ANGLE_LIMIT_Y = 3'd1,
      CSR_BIAS_CODE     = 3'd2,
      CSR_GAIN          = 3'd3,
      CSR_CODE_MAX      = 3'd4,
      CSR_CODE_MIN      = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic [LIMIT_W-1:0] LIMIT_RST    = 15'd5120;
   localparam logic [CODE_W-1:0]  BIAS_RST     = 16'd32768;
   localparam logic [GAIN_W-1:0]  GAIN_RST     = 24'd262144;
   localparam logic [CODE_W-1:0]  CODE_MAX_RST = 16'd65535;
   localparam logic [CODE_W-1:0]  CODE_MIN_RST = 16'd0;

   localparam logic [NUM_FRAMES-1:0][FRAME_W-1:0] INIT_FRAMES = {
      24'h300000, 24'h20000F, 24'h380001, 24'h280001
   };

   localparam logic [NUM_FRAMES-1:0][7:0] CHAN_CMDS = {
      8'h1B, 8'h1A, 8'h19, 8'h18
   };

   // what the front stages hand to the code stages
   typedef struct packed {
      logic                     op;
      logic signed [PROD_W-1:0] prod_x;
      logic signed [PROD_W-1:0] prod_y;
   } prod_type;

   // what the code stages hand to the serializer
   typedef struct packed {
      logic                               op;
      logic [NUM_FRAMES-1:0][CODE_W-1:0]  codes;
   } codes_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [LIMIT_W-1:0] limit_x;
      logic [LIMIT_W-1:0] limit_y;
      logic [CODE_W-1:0]  bias;
      logic [GAIN_W-1:0]  gain;
      logic [CODE_W-1:0]  code_max;
      logic [CODE_W-1:0]  code_min;
   } cfg_type;

endpackage

FILE: rtl/mad_front.sv
// front stages: angle clamp, then angle times gain for both axes
// depends on mad_pkg

module mad_front import mad_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  logic                      in_op,
   input  logic signed [ANGLE_W-1:0] in_angle_x,
   input  logic signed [ANGLE_W-1:0] in_angle_y,
   output logic                      out_valid,
   input  logic                      out_stall,
   output prod_type                  out_data
);

   function automatic logic signed [ANGLE_W-1:0] clamp_angle(
      input logic signed [ANGLE_W-1:0] a,
      input logic [LIMIT_W-1:0]        lim
   );
      logic signed [ANGLE_W:0] a_ext;
      logic signed [ANGLE_W:0] l_pos;
      logic signed [ANGLE_W:0] l_neg;
      a_ext = {a[ANGLE_W-1], a};
      l_pos = {2'b00, lim};
      l_neg = -l_pos;
      if (a_ext > l_pos) a_ext = l_pos;
      if (a_ext < l_neg) a_ext = l_neg;
      return a_ext[ANGLE_W-1:0];
   endfunction

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_op_ff;
   logic signed [ANGLE_W-1:0] s1_ax_ff, s1_ay_ff;
   logic                      s2_valid_ff, s2_valid_in;
   prod_type                  s2_data_ff, s2_data_in;
   logic                      s1_stall, s2_stall;
   logic signed [GAIN_W:0]    gain_s;

   assign s2_stall = s2_valid_ff && out_stall;
   assign s1_stall = s1_valid_ff && s2_stall;
   assign in_stall = s1_stall;

   assign s1_valid_in = s1_stall ? s1_valid_ff : in_valid;
   assign s2_valid_in = s2_stall ? s2_valid_ff : s1_valid_ff;

   assign gain_s = {1'b0, cfg.gain};

   always_comb begin
      s2_data_in.op     = s1_op_ff;
      s2_data_in.prod_x = PROD_W'(s1_ax_ff) * PROD_W'(gain_s);
      s2_data_in.prod_y = PROD_W'(s1_ay_ff) * PROD_W'(gain_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_stall) begin
         s1_op_ff <= in_op;
         s1_ax_ff <= clamp_angle(in_angle_x, cfg.limit_x);
         s1_ay_ff <= clamp_angle(in_angle_y, cfg.limit_y);
      end
      if (!s2_stall) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

FILE: rtl/mad_codes.sv
// code stages: floored offsets plus bias, then the pair clamps A/B and C/D
// depends on mad_pkg

module mad_codes import mad_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   output logic      in_stall,
   input  prod_type  in_data,
   output logic      out_valid,
   input  logic      out_stall,
   output codes_type out_data
);

   localparam int SHIFT = ANGLE_FRAC_BITS + 8;
   localparam int OFF_W = PROD_W - SHIFT;
   localparam int WIDE_W = OFF_W + 2;

   typedef logic signed [WIDE_W-1:0] wide_type;

   logic                      s3_valid_ff, s3_valid_in;
   logic                      s3_op_ff;
   wide_type                  s3_code_ff [NUM_FRAMES];
   wide_type                  s3_code_in [NUM_FRAMES];
   logic                      s4_valid_ff, s4_valid_in;
   codes_type                 s4_data_ff, s4_data_in;
   logic                      s3_stall, s4_stall;
   logic signed [OFF_W-1:0]   off_x, off_y;
   logic                      frac_x, frac_y;
   wide_type                  bias_w, hi_w, lo_w;
   wide_type                  ca, cb, cc, cd;

   assign s4_stall = s4_valid_ff && out_stall;
   assign s3_stall = s3_valid_ff && s4_stall;
   assign in_stall = s3_stall;

   assign s3_valid_in = s3_stall ? s3_valid_ff : in_valid;
   assign s4_valid_in = s4_stall ? s4_valid_ff : s3_valid_ff;

   // floor of product / 2^shift is the arithmetic shift; the negated one
   // rounds down too, so it loses one more when any fraction bit is set
   assign off_x  = in_data.prod_x[PROD_W-1:SHIFT];
   assign off_y  = in_data.prod_y[PROD_W-1:SHIFT];
   assign frac_x = |in_data.prod_x[SHIFT-1:0];
   assign frac_y = |in_data.prod_y[SHIFT-1:0];
   assign bias_w = WIDE_W'({1'b0, cfg.bias});
   assign hi_w   = WIDE_W'({1'b0, cfg.code_max});
   assign lo_w   = WIDE_W'({1'b0, cfg.code_min});

   always_comb begin
      s3_code_in[0] = bias_w + WIDE_W'(off_x);
      s3_code_in[1] = bias_w - WIDE_W'(off_x) - WIDE_W'({1'b0, frac_x});
      s3_code_in[2] = bias_w + WIDE_W'(off_y);
      s3_code_in[3] = bias_w - WIDE_W'(off_y) - WIDE_W'({1'b0, frac_y});
   end

   // clamp order matters: A, then B as left by the A clamp, then C, then D
   always_comb begin
      ca = s3_code_ff[0];
      cb = s3_code_ff[1];
      cc = s3_code_ff[2];
      cd = s3_code_ff[3];
      if (ca > hi_w) begin
         ca = hi_w;
         cb = lo_w;
      end else if (ca < lo_w) begin
         ca = lo_w;
         cb = hi_w;
      end
      if (cb > hi_w) begin
         cb = hi_w;
         ca = lo_w;
      end else if (cb < lo_w) begin
         cb = lo_w;
         ca = hi_w;
      end
      if (cc > hi_w) begin
         cc = hi_w;
         cd = lo_w;
      end else if (cc < lo_w) begin
         cc = lo_w;
         cd = hi_w;
      end
      if (cd > hi_w) begin
         cd = hi_w;
         cc = lo_w;
      end else if (cd < lo_w) begin
         cd = lo_w;
         cc = hi_w;
      end
      s4_data_in.op       = s3_op_ff;
      s4_data_in.codes[0] = ca[CODE_W-1:0];
      s4_data_in.codes[1] = cb[CODE_W-1:0];
      s4_data_in.codes[2] = cc[CODE_W-1:0];
      s4_data_in.codes[3] = cd[CODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!s3_stall) begin
         s3_op_ff   <= in_data.op;
         s3_code_ff <= s3_code_in;
      end
      if (!s4_stall) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

FILE: rtl/mad_serial.sv
// frame serializer: holds one item of four codes and sends one frame a cycle while not stalled
// depends on mad_pkg

module mad_serial import mad_pkg::*; #(
   parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  codes_type          in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output logic [FRAME_W-1:0] out_frame,
   output logic               out_last
);

   localparam logic [CODE_W-1:0] DATA_MASK = CODE_W'((32'd1 << CODE_WIDTH) - 32'd1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_FRAMES - 1);

   logic                valid_ff, valid_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   codes_type           data_ff;
   logic                take, done, load;
   logic [CODE_W-1:0]   data_bits;

   assign take     = valid_ff && !out_stall;
   assign done     = take && (slot_ff == LAST_SLOT);
   assign in_stall = valid_ff && !done;
   assign load     = in_valid && !in_stall;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (load) begin
         valid_in = 1'b1;
         slot_in  = '0;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (take) begin
         slot_in = slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= in_data;
      end
   end

   assign data_bits = data_ff.codes[slot_ff] & DATA_MASK;

   assign out_valid = valid_ff;
   assign out_frame = (data_ff.op == OP_INIT) ? INIT_FRAMES[slot_ff]
                                              : {CHAN_CMDS[slot_ff], data_bits};
   assign out_last  = (slot_ff == LAST_SLOT);

endmodule

FILE: rtl/mirror_angle_to_dac_frames.sv
// top level: configuration registers, front stages, code stages and frame serializer
// depends on mad_pkg, mad_front, mad_codes, mad_serial
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    op, angle_x, angle_y
//   rsp      out        valid / stall    frame, last
//   csr      in         write_enable     index, data
//
// an item gives four frames, one a cycle while rsp is not stalled; the serializer
// takes the next item as the last frame leaves; the stages ahead of it take one a
// cycle unless stalled; the first frame passes four stages plus the serializer
// synchronous reset empties every stage and sets the registers to their defaults
// a stall on rsp holds the frame and backs up stage by stage to req_stall

module mirror_angle_to_dac_frames import mad_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CODE_WIDTH      = CODE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic signed [ANGLE_W-1:0] req_angle_x,
   input  logic signed [ANGLE_W-1:0] req_angle_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [FRAME_W-1:0]        rsp_frame,
   output logic                      rsp_last,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_data
);

   cfg_type   cfg_ff;
   logic      front_valid, front_stall;
   prod_type  front_data;
   logic      codes_valid, codes_stall;
   codes_type codes_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_x  <= LIMIT_RST;
         cfg_ff.limit_y  <= LIMIT_RST;
         cfg_ff.bias     <= BIAS_RST;
         cfg_ff.gain     <= GAIN_RST;
         cfg_ff.code_max <= CODE_MAX_RST;
         cfg_ff.code_min <= CODE_MIN_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ANGLE_LIMIT_X: cfg_ff.limit_x  <= csr_data[LIMIT_W-1:0];
            CSR_ANGLE_LIMIT_Y: cfg_ff.limit_y  <= csr_data[LIMIT_W-1:0];
            CSR_BIAS_CODE:     cfg_ff.bias     <= csr_data[CODE_W-1:0];
            CSR_GAIN:          cfg_ff.gain     <= csr_data[GAIN_W-1:0];
            CSR_CODE_MAX:      cfg_ff.code_max <= csr_data[CODE_W-1:0];
            CSR_CODE_MIN:      cfg_ff.code_min <= csr_data[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   mad_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_op      (req_op),
      .in_angle_x (req_angle_x),
      .in_angle_y (req_angle_y),
      .out_valid  (front_valid),
      .out_stall  (front_stall),
      .out_data   (front_data)
   );

   mad_codes #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_codes (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (codes_valid),
      .out_stall (codes_stall),
      .out_data  (codes_data)
   );

   mad_serial #(
      .CODE_WIDTH (CODE_WIDTH)
   ) u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (codes_valid),
      .in_stall  (codes_stall),
      .in_data   (codes_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_frame (rsp_frame),
      .out_last  (rsp_last)
   );

endmodule

FILE: rtl/mad_checker.sv
// port-level checks on the frame output of the top level, bound to it below
// depends on mad_pkg and mirror_angle_to_dac_frames

module mad_checker import mad_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FRAME_W-1:0] rsp_frame,
   input logic               rsp_last
);

   localparam logic [7:0] CMD_A         = CHAN_CMDS[0];
   localparam logic [7:0] CMD_B         = CHAN_CMDS[1];
   localparam logic [7:0] CMD_D         = CHAN_CMDS[NUM_FRAMES-1];
   localparam logic [7:0] CMD_INIT_LAST = INIT_FRAMES[NUM_FRAMES-1][FRAME_W-1:CODE_W];

   logic [7:0] rsp_cmd;

   assign rsp_cmd = rsp_frame[FRAME_W-1:CODE_W];

   // nothing leaves in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("frame valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame) && $stable(rsp_last))
      else $error("stalled frame changed");

   // the four frames of an item go out without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a run of frames");

   // the fourth frame is channel D or the last init frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_cmd == CMD_D || rsp_cmd == CMD_INIT_LAST)
      else $error("last flag on a wrong frame");

   // channel A is followed by channel B
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_cmd == CMD_A |=> rsp_cmd == CMD_B)
      else $error("channel order broken");

endmodule

bind mirror_angle_to_dac_frames mad_checker u_mad_checker (.*);
